FILE: rtl/gbfd_pkg.sv
package gbfd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned INDEX_W  = 17;
	localparam int unsigned LEN_W    = 17;
	localparam int unsigned CRC_W    = 32;

	localparam logic [BYTE_W-1:0]  SYNC_A    = 8'hAA;
	localparam logic [BYTE_W-1:0]  SYNC_B    = 8'h44;
	localparam logic [BYTE_W-1:0]  SYNC_C    = 8'h12;
	localparam logic [LEN_W-1:0]   HDR_LEN   = 17'd28;
	localparam logic [LEN_W-1:0]   LIMIT_RST = 17'd16380;
	localparam logic [CRC_W-1:0]   CRC_POLY  = 32'hEDB88320;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_LEN_ERR   = 3'd1,
		ST_CRC_ERR   = 3'd2,
		ST_ZERO_WEEK = 3'd3,
		ST_GOOD      = 3'd4
	} frame_status_t;

	// Everything reported for one byte.
	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               in_frame;
		logic [INDEX_W-1:0] index;
		logic               frame_end;
		frame_status_t      status;
		logic [15:0]        msg_id;
		logic [15:0]        week;
		logic [31:0]        tow;
		logic [15:0]        plen;
	} gbfd_res_t;

	// Reflected CRC-32 update by one byte, one bit per step.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// CRC after the three sync bytes, from a zero start.
	localparam logic [CRC_W-1:0] CRC_SYNC =
		crc_byte(crc_byte(crc_byte(32'd0, SYNC_A), SYNC_B), SYNC_C);

endpackage

FILE: rtl/gnss_binary_frame_deframer.sv
// Path: a byte accepted on the input is held in the input register, then in the result
// register, from which it is presented on the output.
// Throughput: one beat per cycle while the output is not stalled, set by the single-byte
// CRC-32 update and the frame counter; stage one can fill while the output is stalled.
// Reset: arst_n clears the frame state to hunting, the length limit to 16380
// and both stage valids; payload registers are not reset.
module gnss_binary_frame_deframer
	import gbfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration: frame length limit, written while the block is idle.
	input  logic               cfg_we,
	input  logic [LEN_W-1:0]   cfg_wdata,
	// Input channel: one received byte per beat.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [BYTE_W-1:0]  byte_in,
	// Output channel: one result per received byte.
	output logic               out_valid,
	input  logic               out_stall,
	output logic [BYTE_W-1:0]  byte_out,
	output logic               in_frame,
	output logic [INDEX_W-1:0] byte_index,
	output logic               frame_end,
	output logic [2:0]         frame_status,
	output logic [15:0]        msg_id,
	output logic [15:0]        week_number,
	output logic [31:0]        tow_ms,
	output logic [15:0]        payload_len
);

	// Stage one simply captures the incoming byte. The deframing logic then
	// works between this register and the result register, so the CRC and
	// counter paths never start at an input pin.
	logic              s1_valid_q;
	logic [BYTE_W-1:0] s1_byte_q;

	// The result register is free when it is empty or its beat is being
	// taken this cycle. Stage one moves on whenever that is so, and a new
	// byte may enter stage one when stage one is empty or moving on. This
	// keeps a full rate of one beat per cycle while a stall ripples back
	// only as far as it needs to.
	logic      out_free;
	logic      s1_adv;
	gbfd_res_t res;

	assign out_free = !out_valid || !out_stall;
	assign s1_adv   = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s1_byte_q <= byte_in;
		end
	end

	// The deframer holds the hunt history, the frame counter, the CRC and the
	// captured header fields. Its state moves only when a byte leaves stage
	// one, so the result it presents belongs to exactly that byte.
	gbfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (s1_adv),
		.data      (s1_byte_q),
		.res       (res)
	);

	// Result register. It is loaded whenever stage one advances and held
	// otherwise, so a stalled beat keeps its payload.
	logic      out_valid_q;
	gbfd_res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_out     = res_q.data;
	assign in_frame     = res_q.in_frame;
	assign byte_index   = res_q.index;
	assign frame_end    = res_q.frame_end;
	assign frame_status = res_q.status;
	assign msg_id       = res_q.msg_id;
	assign week_number  = res_q.week;
	assign tow_ms       = res_q.tow;
	assign payload_len  = res_q.plen;

	// A status is reported exactly on the byte that closes a frame.
	a_status_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((frame_status != ST_NONE) == frame_end))
		else $error("frame status and frame end disagree");

	// Only a byte inside a synced frame can close one.
	a_end_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> in_frame)
		else $error("frame end reported on a hunting byte");

	// Hunting bytes carry no position.
	a_hunt_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_frame) |-> (byte_index == '0))
		else $error("hunting byte with a non-zero index");

	// The input is held off only when both stages are occupied and stalled.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule

FILE: rtl/gbfd_core.sv
module gbfd_core
	import gbfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LEN_W-1:0]  cfg_wdata,
	input  logic              step,
	input  logic [BYTE_W-1:0] data,
	output gbfd_res_t         res
);

	localparam logic [INDEX_W-1:0] IDX_MSG_LO  = 17'd4;
	localparam logic [INDEX_W-1:0] IDX_MSG_HI  = 17'd5;
	localparam logic [INDEX_W-1:0] IDX_LEN_LO  = 17'd8;
	localparam logic [INDEX_W-1:0] IDX_LEN_HI  = 17'd9;
	localparam logic [INDEX_W-1:0] IDX_HDR_END = 17'd10;
	localparam logic [INDEX_W-1:0] IDX_WEEK_LO = 17'd14;
	localparam logic [INDEX_W-1:0] IDX_WEEK_HI = 17'd15;
	localparam logic [INDEX_W-1:0] IDX_TOW_0   = 17'd16;
	localparam logic [INDEX_W-1:0] IDX_TOW_3   = 17'd19;
	localparam logic [INDEX_W-1:0] IDX_SYNC_C  = 17'd2;
	localparam logic [INDEX_W-1:0] IDX_FIRST   = 17'd3;
	localparam logic [INDEX_W-1:0] CRC_BYTES   = 17'd3;

	logic [LEN_W-1:0]   limit_q;
	logic [15:0]        hist_q, hist_n;
	logic [INDEX_W-1:0] count_q, count_n;
	logic [LEN_W-1:0]   total_q, total_n;
	logic [CRC_W-1:0]   crc_q, crc_n;
	logic [CRC_W-1:0]   rcrc_q, rcrc_n;
	logic [15:0]        msg_q, msg_n;
	logic [15:0]        week_q, week_n;
	logic [31:0]        tow_q, tow_n;
	logic               early;
	logic [LEN_W-1:0]   plen_full;

	always_comb begin
		hist_n  = hist_q;
		count_n = count_q;
		total_n = total_q;
		crc_n   = crc_q;
		rcrc_n  = rcrc_q;
		msg_n   = msg_q;
		week_n  = week_q;
		tow_n   = tow_q;
		early   = 1'b0;
		res.in_frame  = 1'b0;
		res.index     = '0;
		res.frame_end = 1'b0;
		res.status    = ST_NONE;

		if (count_q == '0) begin
			if (hist_q == {SYNC_A, SYNC_B} && data == SYNC_C) begin
				count_n = IDX_FIRST;
				hist_n  = '0;
				total_n = '0;
				rcrc_n  = '0;
				msg_n   = '0;
				week_n  = '0;
				tow_n   = '0;
				crc_n   = CRC_SYNC;
				res.in_frame = 1'b1;
				res.index    = IDX_SYNC_C;
				early        = 1'b1;
			end else begin
				hist_n = {hist_q[7:0], data};
			end
		end else begin
			res.in_frame = 1'b1;
			res.index    = count_q;
			count_n      = count_q + 17'd1;
			if (count_q < IDX_HDR_END || count_q < total_q) begin
				crc_n = crc_byte(crc_q, data);
			end
			if (count_q == IDX_MSG_LO) msg_n = {msg_q[15:8], data};
			if (count_q == IDX_MSG_HI) msg_n = {data, msg_q[7:0]};
			if (count_q == IDX_LEN_LO) total_n = {9'd0, data};
			if (count_q == IDX_LEN_HI) total_n = {1'b0, data, total_q[7:0]} + HDR_LEN;
			if (count_q == IDX_WEEK_LO) week_n = {week_q[15:8], data};
			if (count_q == IDX_WEEK_HI) week_n = {data, week_q[7:0]};
			if (count_q >= IDX_TOW_0 && count_q <= IDX_TOW_3) begin
				tow_n = {data, tow_q[31:8]};
			end
			early = (count_q < IDX_LEN_HI);

			if (count_q == IDX_LEN_HI && total_n > limit_q) begin
				res.frame_end = 1'b1;
				res.status    = ST_LEN_ERR;
			end else if (count_q >= IDX_HDR_END && count_q >= total_n) begin
				rcrc_n = {data, rcrc_q[31:8]};
				if (count_q == total_n + CRC_BYTES) begin
					res.frame_end = 1'b1;
					priority if (crc_n != rcrc_n) begin
						res.status = ST_CRC_ERR;
					end else if (week_n == '0) begin
						res.status = ST_ZERO_WEEK;
					end else begin
						res.status = ST_GOOD;
					end
				end
			end
			if (res.frame_end) begin
				count_n = '0;
				hist_n  = '0;
			end
		end

		plen_full  = total_n - HDR_LEN;
		res.data   = data;
		res.msg_id = msg_n;
		res.week   = week_n;
		res.tow    = tow_n;
		res.plen   = (!early && total_n >= HDR_LEN) ? plen_full[15:0] : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			hist_q  <= '0;
			count_q <= '0;
			total_q <= '0;
			crc_q   <= '0;
			rcrc_q  <= '0;
			msg_q   <= '0;
			week_q  <= '0;
			tow_q   <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (step) begin
				hist_q  <= hist_n;
				count_q <= count_n;
				total_q <= total_n;
				crc_q   <= crc_n;
				rcrc_q  <= rcrc_n;
				msg_q   <= msg_n;
				week_q  <= week_n;
				tow_q   <= tow_n;
			end
		end
	end

endmodule

FILE: verif/gnss_binary_frame_deframer_test.sv
`timescale 1ns / 100ps

module gnss_binary_frame_deframer_test;

	import gbfd_pkg::*;

	// Cycles with no beat on either channel before the run is abandoned. The longest
	// legitimate quiet stretch is the receiver hold-off below.
	localparam int unsigned WATCHDOG_LIMIT         = 2000;
	// Cycles allowed after the last result before the block counts as idle.
	localparam int unsigned SETTLE_CYCLES          = 8;
	localparam int unsigned HOLDOFF_CYCLES         = 300;
	localparam int unsigned RANDOM_BYTES_PER_PHASE = 160;
	localparam int unsigned MAX_PRINTS             = 50;
	localparam logic [LEN_W-1:0] LIMIT_MIN         = 17'd28;
	localparam logic [LEN_W-1:0] LIMIT_MAX         = 17'd65563;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [LEN_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [BYTE_W-1:0]  byte_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [BYTE_W-1:0]  byte_out;
	logic               in_frame;
	logic [INDEX_W-1:0] byte_index;
	logic               frame_end;
	logic [2:0]         frame_status;
	logic [15:0]        msg_id;
	logic [15:0]        week_number;
	logic [31:0]        tow_ms;
	logic [15:0]        payload_len;

	gnss_binary_frame_deframer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_in      (byte_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_out     (byte_out),
		.in_frame     (in_frame),
		.byte_index   (byte_index),
		.frame_end    (frame_end),
		.frame_status (frame_status),
		.msg_id       (msg_id),
		.week_number  (week_number),
		.tow_ms       (tow_ms),
		.payload_len  (payload_len)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Deframer predictor. Its state mirrors the block after reset and moves on
	// by one byte for every beat accepted on the input channel.
	// ------------------------------------------------------------------------
	logic [15:0]        hunt_bytes = '0;   // last two hunted bytes, older one high
	logic [INDEX_W-1:0] frame_pos = '0;    // zero while hunting for sync
	logic [LEN_W-1:0]   total_len = '0;
	logic [CRC_W-1:0]   crc_run = '0;
	logic [CRC_W-1:0]   crc_rx = '0;
	logic [15:0]        hdr_msg = '0;
	logic [15:0]        hdr_week = '0;
	logic [31:0]        hdr_tow = '0;
	logic [LEN_W-1:0]   frame_limit = LIMIT_RST;

	gbfd_res_t byte_reports_due[$];
	int unsigned fail_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned idle_cycles = 0;

	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;
	int unsigned holdoff_request = 0;
	int unsigned holdoff_left = 0;

	// Reflected CRC-32 over one byte, feeding the data in least significant bit first.
	function automatic logic [CRC_W-1:0] crc32_step(input logic [CRC_W-1:0] acc,
		input logic [7:0] d);
		logic [CRC_W-1:0] c;
		logic fb;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Works out the report for one received byte and advances the predictor state.
	function automatic gbfd_res_t deframe_byte(input logic [7:0] b);
		gbfd_res_t r;
		bit early;
		int unsigned idx;
		r = '0;
		r.data = b;
		r.status = ST_NONE;
		early = 1'b0;
		if (frame_pos == 0) begin
			if (hunt_bytes == {SYNC_A, SYNC_B} && b == SYNC_C) begin
				// Third sync byte: the frame starts here, header registers are cleared.
				frame_pos = 17'd3;
				hunt_bytes = '0;
				total_len = '0;
				crc_rx = '0;
				hdr_msg = '0;
				hdr_week = '0;
				hdr_tow = '0;
				crc_run = crc32_step(crc32_step(crc32_step('0, SYNC_A), SYNC_B), SYNC_C);
				r.in_frame = 1'b1;
				r.index = 17'd2;
				early = 1'b1;
			end else begin
				hunt_bytes = {hunt_bytes[7:0], b};
			end
		end else begin
			idx = frame_pos;
			r.in_frame = 1'b1;
			r.index = frame_pos;
			frame_pos = frame_pos + 1'b1;
			if (idx < 10 || idx < total_len) begin
				crc_run = crc32_step(crc_run, b);
			end
			case (idx)
			4: hdr_msg[7:0] = b;
			5: hdr_msg[15:8] = b;
			8: total_len = {9'd0, b};
			9: total_len = {1'b0, b, total_len[7:0]} + HDR_LEN;
			14: hdr_week[7:0] = b;
			15: hdr_week[15:8] = b;
			16, 17, 18, 19: hdr_tow = {b, hdr_tow[31:8]};
			default: ;
			endcase
			if (idx < 9) begin
				early = 1'b1;
			end
			if (idx == 9 && total_len > frame_limit) begin
				r.frame_end = 1'b1;
				r.status = ST_LEN_ERR;
			end else if (idx >= 10 && idx >= total_len) begin
				// Trailer bytes arrive least significant first.
				crc_rx = {b, crc_rx[31:8]};
				if (idx + 1 == total_len + 4) begin
					r.frame_end = 1'b1;
					if (crc_run != crc_rx) begin
						r.status = ST_CRC_ERR;
					end else if (hdr_week == 16'd0) begin
						r.status = ST_ZERO_WEEK;
					end else begin
						r.status = ST_GOOD;
					end
				end
			end
			if (r.frame_end) begin
				// A fresh sync sequence is needed after every frame end.
				frame_pos = '0;
				hunt_bytes = '0;
			end
		end
		if (!early && total_len >= HDR_LEN) begin
			r.plen = 16'(total_len - HDR_LEN);
		end
		r.msg_id = hdr_msg;
		r.week = hdr_week;
		r.tow = hdr_tow;
		return r;
	endfunction

	// The predictor follows each accepted input beat and each register write.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				frame_limit = cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				byte_reports_due.push_back(deframe_byte(byte_in));
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fail_count++;
		if (fail_count <= MAX_PRINTS) begin
			$display("MISMATCH %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		end
	endtask

	// Every result beat is matched against the oldest report still due.
	always @(posedge clk) begin
		gbfd_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (byte_reports_due.size() == 0) begin
				report_mismatch("result with nothing due, byte_out", 32'(byte_out), '0);
			end else begin
				want = byte_reports_due.pop_front();
				if (byte_out !== want.data)
					report_mismatch("byte_out", 32'(byte_out), 32'(want.data));
				if (in_frame !== want.in_frame)
					report_mismatch("in_frame", 32'(in_frame), 32'(want.in_frame));
				if (byte_index !== want.index)
					report_mismatch("byte_index", 32'(byte_index), 32'(want.index));
				if (frame_end !== want.frame_end)
					report_mismatch("frame_end", 32'(frame_end), 32'(want.frame_end));
				if (frame_status !== want.status)
					report_mismatch("frame_status", 32'(frame_status), 32'(want.status));
				if (msg_id !== want.msg_id)
					report_mismatch("msg_id", 32'(msg_id), 32'(want.msg_id));
				if (week_number !== want.week)
					report_mismatch("week_number", 32'(week_number), 32'(want.week));
				if (tow_ms !== want.tow)
					report_mismatch("tow_ms", tow_ms, want.tow);
				if (payload_len !== want.plen)
					report_mismatch("payload_len", 32'(payload_len), 32'(want.plen));
			end
		end
	end

	// Receiver: random stalls, none at all in steady mode, and a long hold-off when
	// one is requested. The hold-off is counted here so that the sender carries on.
	always @(negedge clk) begin
		if (holdoff_request != 0) begin
			holdoff_left = holdoff_request;
			holdoff_request = 0;
		end
		if (holdoff_left != 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else if (recv_steady) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 17);
		end
	end

	// Watchdog: the run is abandoned after too long without a beat on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers. They are entered at a falling edge and return at one.
	// ------------------------------------------------------------------------

	// Offers one byte and returns once the beat has been taken. Valid stays high on
	// return, so back-to-back bytes go out on consecutive cycles.
	task automatic send_byte(input logic [7:0] value);
		if (!send_steady && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 17);
		end
		in_valid <= 1'b1;
		byte_in <= value;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Lowers valid, then waits for every report still due and then for the settle time.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (byte_reports_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_frame_limit(input logic [LEN_W-1:0] limit);
		drain_results();
		cfg_wdata <= limit;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Sends a frame with the given header fields and payload length. A non-zero cut
	// stops after that many bytes. The trailer is the true CRC xor crc_twist, or
	// crc_twist itself when crc_forced is set. plant_sync puts the sync sequence at
	// the start of the payload.
	task automatic send_frame(input logic [15:0] msg, input logic [15:0] week,
		input logic [31:0] tow, input int unsigned plen, input int unsigned cut,
		input logic [31:0] crc_twist, input bit crc_forced, input bit plant_sync);
		int unsigned total;
		int unsigned beats;
		logic [CRC_W-1:0] crc;
		logic [CRC_W-1:0] trailer;
		logic [7:0] b;
		total = HDR_LEN + plen;
		beats = (cut == 0) ? total + 4 : cut;
		crc = '0;
		trailer = '0;
		for (int unsigned i = 0; i < beats; i++) begin
			if (i >= total) begin
				b = trailer[8*(i-total) +: 8];
			end else begin
				case (i)
				0: b = SYNC_A;
				1: b = SYNC_B;
				2: b = SYNC_C;
				4: b = msg[7:0];
				5: b = msg[15:8];
				8: b = plen[7:0];
				9: b = plen[15:8];
				14: b = week[7:0];
				15: b = week[15:8];
				16, 17, 18, 19: b = tow[8*(i-16) +: 8];
				default: b = 8'($urandom_range(255));
				endcase
				if (plant_sync) begin
					if (i == 28) b = SYNC_A;
					else if (i == 29) b = SYNC_B;
					else if (i == 30) b = SYNC_C;
				end
				crc = crc32_step(crc, b);
				if (i == total - 1) begin
					trailer = crc_forced ? crc_twist : crc ^ crc_twist;
				end
			end
			send_byte(b);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Noise and near misses of the sync sequence while hunting, then a sync that is
	// found only because the last two hunted bytes matter.
	task automatic test_hunt_and_sync();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_C);
		send_byte(SYNC_A);
		send_byte(SYNC_B);
		send_byte(8'h00);
		send_byte(SYNC_C);
		send_byte(SYNC_B);
		send_byte(SYNC_C);
		send_byte(8'h55);
		// A repeated first sync byte still leads into a frame.
		send_byte(SYNC_A);
		send_frame(16'h1234, 16'h0800, 32'h0102_0304, 0, 0, '0, 1'b0, 1'b0);
	endtask

	// Frames that end at their trailer: good, with a zero week and with a CRC error.
	task automatic test_frame_outcomes();
		// Header fields at their extremes, good CRC.
		send_frame(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, '0, 1'b0, 1'b0);
		send_frame(16'h0000, 16'h0001, 32'h0000_0000, 5, 0, '0, 1'b0, 1'b0);
		// Good CRC but a zero week.
		send_frame(16'($urandom), 16'h0000, $urandom, 4, 0, '0, 1'b0, 1'b0);
		// One trailer bit wrong.
		send_frame(16'($urandom), 16'h0456, $urandom, 3, 0, 32'h0000_0100, 1'b0, 1'b0);
		// The sync sequence inside the payload is plain frame data.
		send_frame(16'($urandom), 16'h0789, $urandom, 8, 0, '0, 1'b0, 1'b1);
		// The trailer ends in the first two sync bytes; the lone third one after the
		// frame end must not start a frame, since the hunt history is cleared.
		send_frame(16'($urandom), 16'h0321, $urandom, 2, 0, 32'h44AA_5A5A, 1'b1, 1'b0);
		send_byte(SYNC_C);
		send_byte(8'h00);
		// Frames straight after one another.
		send_frame(16'($urandom), 16'h0042, $urandom, 1, 0, '0, 1'b0, 1'b0);
		send_frame(16'($urandom), 16'h0043, $urandom, 1, 0, '0, 1'b0, 1'b0);
	endtask

	// The length limit at its extremes and just around them.
	task automatic test_length_limits();
		write_frame_limit(LIMIT_MIN);
		send_frame(16'h0028, 16'h0100, $urandom, 0, 0, '0, 1'b0, 1'b0);
		send_frame(16'h0029, 16'h0100, $urandom, 1, 10, '0, 1'b0, 1'b0);
		// Below the header length nothing can pass.
		write_frame_limit(LIMIT_MIN - 1'b1);
		send_frame(16'h0027, 16'h0100, $urandom, 0, 10, '0, 1'b0, 1'b0);
		send_byte(8'h00);
		write_frame_limit(LIMIT_RST);
		send_frame(16'h3FFC, 16'h0100, $urandom, 16353, 10, '0, 1'b0, 1'b0);
		// The largest length field against a limit one short of the frame length it gives,
		// then a frame under the top limit.
		write_frame_limit(LIMIT_MAX - 1'b1);
		send_frame(16'hFFFE, 16'h0901, $urandom, 65535, 10, '0, 1'b0, 1'b0);
		write_frame_limit(LIMIT_MAX);
		send_frame(16'hFFFD, 16'h0901, $urandom, 4, 0, '0, 1'b0, 1'b0);
		write_frame_limit(LIMIT_RST);
	endtask

	// A stretch with no idling on either side.
	task automatic test_back_to_back();
		send_steady = 1'b1;
		recv_steady = 1'b1;
		repeat (8) begin
			send_frame(16'($urandom), 16'($urandom), $urandom, $urandom_range(16), 0, '0,
				1'b0, 1'b0);
		end
		repeat (20) send_byte(8'($urandom));
		drain_results();
		send_steady = 1'b0;
		recv_steady = 1'b0;
	endtask

	// The receiver holds off for a long stretch while bytes keep coming, so the block
	// fills up and stalls its input.
	task automatic test_receiver_holdoff();
		holdoff_request = HOLDOFF_CYCLES;
		send_frame(16'($urandom), 16'h0A0B, $urandom, 120, 0, '0, 1'b0, 1'b0);
		drain_results();
	endtask

	// The sender waits in the middle of the traffic until every report has come.
	task automatic test_sender_pause();
		send_frame(16'($urandom), 16'h0B0C, $urandom, 10, 0, '0, 1'b0, 1'b0);
		send_byte(SYNC_A);
		send_byte(SYNC_B);
		drain_results();
		send_byte(SYNC_C);
		repeat (40) send_byte(8'($urandom));
		drain_results();
		send_frame(16'($urandom), 16'h0C0D, $urandom, 6, 0, '0, 1'b0, 1'b0);
	endtask

	// Mostly well-formed frames with random content, the rest broken frames and
	// noise, over several limit settings.
	task automatic test_random_traffic();
		logic [LEN_W-1:0] phase_limit[4];
		int unsigned start_count;
		int unsigned roll;
		int unsigned plen;
		int unsigned total;
		logic [15:0] wk;
		logic [31:0] twist;
		phase_limit[0] = LIMIT_RST;
		phase_limit[1] = 17'($urandom_range(100, 28));
		phase_limit[2] = LIMIT_MAX;
		phase_limit[3] = 17'($urandom_range(65563, 28));
		for (int p = 0; p < 4; p++) begin
			write_frame_limit(phase_limit[p]);
			start_count = bytes_sent;
			while (bytes_sent - start_count < RANDOM_BYTES_PER_PHASE) begin
				// Short payloads dominate so that many frames fit in the phase.
				roll = $urandom_range(99);
				if (roll < 85) plen = $urandom_range(48);
				else if (roll < 97) plen = $urandom_range(300, 49);
				else plen = $urandom_range(1500, 301);
				total = HDR_LEN + plen;
				wk = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
				twist = ($urandom_range(99) < 12) ? (32'd1 << $urandom_range(31)) : '0;
				roll = $urandom_range(99);
				if (roll < 70) begin
					// An over-long frame is cut after its length field.
					send_frame(16'($urandom), wk, $urandom, plen,
						(total > frame_limit) ? 10 : 0, twist, 1'b0,
						$urandom_range(19) == 0);
				end else if (roll < 78 && frame_limit < LIMIT_MAX) begin
					send_frame(16'($urandom), wk, $urandom,
						$urandom_range(65535, frame_limit - 27), 10, '0, 1'b0, 1'b0);
				end else if (roll < 88) begin
					send_frame(16'($urandom), wk, $urandom, plen,
						$urandom_range(total + 3, 1), twist, 1'b0, 1'b0);
				end else begin
					repeat ($urandom_range(12, 1)) begin
						case ($urandom_range(9))
						0: send_byte(SYNC_A);
						1: send_byte(SYNC_B);
						2: send_byte(SYNC_C);
						default: send_byte(8'($urandom));
						endcase
					end
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_hunt_and_sync();
		test_frame_outcomes();
		test_length_limits();
		test_back_to_back();
		test_receiver_holdoff();
		test_sender_pause();
		test_random_traffic();
		drain_results();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
